// ===== hw/rtl/escaped_frame_deframer_xor_core_assert.svh =====
// ----------------------------------------------------------------------------
// escaped_frame_deframer_xor_core_assert.svh
// assertion macros for the deframer rtl, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_DEFRAMER_XOR_CORE_ASSERT_SVH
`define ESCAPED_FRAME_DEFRAMER_XOR_CORE_ASSERT_SVH

// condition must hold in the same cycle
`define EFDX_ASSERT_IMPLY(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// condition must hold in the following cycle
`define EFDX_ASSERT_NEXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

// ===== hw/rtl/efdx_pkg.sv =====
// ----------------------------------------------------------------------------
// efdx_pkg
// types and constants of the escaped frame deframer with xor checksum
// ----------------------------------------------------------------------------
package efdx_pkg;

	// default size of the frame data buffer
	localparam int unsigned MAX_DATA_DEF = 16;

	// configuration port
	localparam int unsigned CFG_REGS  = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_3 = 2'd3;

	// framing bytes
	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_OR     = 8'h70;

	// result status codes
	localparam logic [1:0] STATUS_GOOD     = 2'd0;
	localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	// parser phase
	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_TYPE = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_CSUM = 3'd4
	} phase_t;

	// readout sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	// one result item
	typedef struct packed {
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic [3:0] byte_index;
		logic [7:0] data_byte;
		logic [1:0] status;
		logic       last;
	} result_t;

endpackage

// ===== hw/rtl/efdx_store.sv =====
// ----------------------------------------------------------------------------
// efdx_store
// frame data buffer: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module efdx_store #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data valid in the cycle after the address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/escaped_frame_deframer_xor_core.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_deframer_xor_core
// byte-stuffed frame parser with xor checksum and a type accept map
// ----------------------------------------------------------------------------
// A new received byte is taken whenever the input is open; the input is
// held off while the output register is full and not being taken, and for
// the whole of a readout. A frame that ends with a good checksum and a
// nonzero length is read out of the data buffer one data byte at a time:
// each is read from the synchronous buffer, then loaded into the output
// register once that is free, so the input stays closed until the last
// byte of such a frame is loaded. Error and empty results are formed
// straight from the received byte. The data buffer needs no clearing after
// reset: only entries written in the current frame are read back.
module escaped_frame_deframer_xor_core
	import efdx_pkg::*;
#(
	parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// received bytes
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	// results
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           frame_type,
	output logic [7:0]           frame_length,
	output logic [3:0]           byte_index,
	output logic [7:0]           data_byte,
	output logic [1:0]           status,
	output logic                 last
);

	localparam int unsigned CNT_W  = $clog2(MAX_DATA + 1);
	localparam int unsigned ADDR_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
	localparam logic [7:0]       MAX_LEN = 8'(MAX_DATA);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATA);

	// accept map
	logic [CFG_W-1:0] map_q [CFG_REGS];
	logic [255:0]     acc_map;

	// parser state
	logic             esc_q, esc_d;
	phase_t           phase_q, phase_d;
	logic [7:0]       type_q, type_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       xor_q, xor_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// readout and output
	state_t           state_q, state_d;
	logic [ADDR_W-1:0] rd_idx_q;
	logic             out_valid_q;
	result_t          out_res_q;
	result_t          res;
	logic             res_load;
	logic             start_drain;
	logic             drain_load;
	logic             rd_en;
	logic             wr_en;
	logic             out_free;
	logic             in_fire;
	logic             rd_last;
	logic [7:0]       rd_data;
	logic [7:0]       cu;
	logic             acc_new;
	logic             acc_held;

	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign acc_map  = {map_q[3], map_q[2], map_q[1], map_q[0]};

	// unescaped byte and accept lookups
	assign cu       = esc_q ? (rx_byte | ESC_OR) : rx_byte;
	assign acc_new  = acc_map[cu];
	assign acc_held = acc_map[type_q];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) begin
				map_q[i] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAP_0: map_q[0] <= cfg_data;
				REG_MAP_1: map_q[1] <= cfg_data;
				REG_MAP_2: map_q[2] <= cfg_data;
				REG_MAP_3: map_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser next state and direct results
	always_comb begin
		esc_d       = esc_q;
		phase_d     = phase_q;
		type_d      = type_q;
		len_d       = len_q;
		xor_d       = xor_q;
		cnt_d       = cnt_q;
		wr_en       = 1'b0;
		res_load    = 1'b0;
		start_drain = 1'b0;
		res         = '0;
		res.frame_type   = type_q;
		res.frame_length = len_q;
		res.last         = 1'b1;
		if (in_fire) begin
			if (rx_byte == START_BYTE) begin
				esc_d   = 1'b0;
				phase_d = PH_TYPE;
				xor_d   = '0;
			end else if (rx_byte == ESC_BYTE) begin
				esc_d = 1'b1;
			end else begin
				esc_d = 1'b0;
				if (phase_q != PH_CSUM) begin
					xor_d = xor_q ^ cu;
				end
				case (phase_q)
					PH_TYPE: begin
						type_d  = cu;
						phase_d = acc_new ? PH_LEN : PH_WAIT;
					end
					PH_LEN: begin
						len_d = cu;
						if (!acc_held) begin
							phase_d = PH_WAIT;
						end else if (cu == 8'd0) begin
							phase_d = PH_CSUM;
						end else if (cu > MAX_LEN) begin
							res_load         = 1'b1;
							res.frame_length = cu;
							res.status       = STATUS_TOO_LONG;
							phase_d          = PH_WAIT;
						end else begin
							cnt_d   = '0;
							phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						if (!acc_held || cnt_q >= MAX_CNT) begin
							phase_d = PH_WAIT;
						end else begin
							wr_en = 1'b1;
							cnt_d = cnt_q + 1'b1;
							if (8'(cnt_q) + 8'd1 == len_q) begin
								phase_d = PH_CSUM;
							end
						end
					end
					PH_CSUM: begin
						if (xor_q == cu) begin
							if (len_q == 8'd0) begin
								res_load   = 1'b1;
								res.status = STATUS_GOOD;
							end else begin
								start_drain = 1'b1;
							end
						end else begin
							res_load   = 1'b1;
							res.status = STATUS_BAD_SUM;
						end
						phase_d = PH_WAIT;
					end
					default: ;
				endcase
			end
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			phase_q <= PH_WAIT;
			type_q  <= '0;
			len_q   <= '0;
			xor_q   <= '0;
			cnt_q   <= '0;
		end else begin
			esc_q   <= esc_d;
			phase_q <= phase_d;
			type_q  <= type_d;
			len_q   <= len_d;
			xor_q   <= xor_d;
			cnt_q   <= cnt_d;
		end
	end

	// frame data buffer
	efdx_store #(
		.DEPTH  (MAX_DATA),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data (cu),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	assign rd_last = (8'(rd_idx_q) + 8'd1 == len_q);

	// readout sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_drain) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: begin
				if (out_free) begin
					state_d = rd_last ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// readout sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		rd_en      = 1'b0;
		drain_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready   = out_free;
			ST_READ: rd_en      = 1'b1;
			ST_LOAD: drain_load = out_free;
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (start_drain) begin
				rd_idx_q <= '0;
			end else if (drain_load) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load || drain_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_res_q <= res;
		end else if (drain_load) begin
			out_res_q.frame_type   <= type_q;
			out_res_q.frame_length <= len_q;
			out_res_q.byte_index   <= 4'(rd_idx_q);
			out_res_q.data_byte    <= rd_data;
			out_res_q.status       <= STATUS_GOOD;
			out_res_q.last         <= rd_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_type   = out_res_q.frame_type;
	assign frame_length = out_res_q.frame_length;
	assign byte_index   = out_res_q.byte_index;
	assign data_byte    = out_res_q.data_byte;
	assign status       = out_res_q.status;
	assign last         = out_res_q.last;

	// checks
	`include "escaped_frame_deframer_xor_core_assert.svh"

	`EFDX_ASSERT_IMPLY(a_read_in_range, state_q == ST_READ, 8'(rd_idx_q) < len_q, "readout past length")
	`EFDX_ASSERT_IMPLY(a_data_below_len, phase_q == PH_DATA, 8'(cnt_q) < len_q, "data count reached length")
	`EFDX_ASSERT_NEXT(a_load_holds, (state_q == ST_LOAD) && !out_free, state_q == ST_LOAD, "read data dropped")
	`EFDX_ASSERT_IMPLY(a_no_input_in_drain, state_q != ST_IDLE, !in_ready, "input open during readout")

endmodule

// ===== verif/escaped_frame_deframer_xor_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_xor_core_tb
// self-checking testbench for the byte-stuffed frame deframer with xor sum
// ----------------------------------------------------------------------------
// Raw link bytes are offered in random bursts while the result side stalls
// on its own pattern. Every accepted byte runs through a behavioral copy of
// the parser in this file, which queues the results that byte must produce;
// every accepted result is checked field by field against the oldest one.
// Directed tests cover the framing corner cases, random tests cover mostly
// well-formed frames with some noise, and one test holds the output off
// long enough that the block stalls its input.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_xor_core_tb;
	import efdx_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// dut ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           frame_type;
	logic [7:0]           frame_length;
	logic [3:0]           byte_index;
	logic [7:0]           data_byte;
	logic [1:0]           status;
	logic                 last;

	// parser state as the block should hold it
	logic [255:0] accept_bits = '0;
	logic         esc_pending = 1'b0;
	phase_t       parse_phase = PH_WAIT;
	logic [7:0]   held_type = '0;
	logic [7:0]   held_length = '0;
	logic [7:0]   running_xor = '0;
	int           data_count = 0;
	logic [7:0]   frame_buf [MAX_DATA_DEF];

	// results still owed by the block, oldest first
	result_t expected_results [$];

	// bookkeeping
	int          fail_count = 0;
	int          shown_count = 0;
	int          predicted_results = 0;
	int          counted_bytes = 0;
	int unsigned cycle_count = 0;

	// sender pacing
	bit offering = 1'b0;
	bit tx_gaps = 1'b1;
	int tx_burst_left = 0;

	// receiver pacing
	rx_mode_t    rx_mode = RX_ALWAYS;
	logic [12:0] rx_pattern = 13'b1101101110011;
	int          hold_req = 0;
	int          hold_ack = 0;
	int          hold_len = 0;
	int          hold_left = 0;

	escaped_frame_deframer_xor_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.byte_index   (byte_index),
		.data_byte    (data_byte),
		.status       (status),
		.last         (last)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL escaped_frame_deframer_xor_core");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// frame parser prediction
	// ------------------------------------------------------------------------

	function automatic void expect_result(input logic [3:0] idx, input logic [7:0] value,
			input logic [1:0] code, input logic is_last);
		result_t r;
		r.frame_type   = held_type;
		r.frame_length = held_length;
		r.byte_index   = idx;
		r.data_byte    = value;
		r.status       = code;
		r.last         = is_last;
		expected_results.push_back(r);
		predicted_results++;
	endfunction

	// advance the parser by one raw byte and queue what it must emit
	function automatic void deframe_byte(input logic [7:0] raw);
		logic [7:0] c;
		c = raw;
		if (c == START_BYTE) begin
			esc_pending = 1'b0;
			parse_phase = PH_TYPE;
			running_xor = '0;
		end else if (c == ESC_BYTE) begin
			esc_pending = 1'b1;
		end else begin
			if (esc_pending) begin
				esc_pending = 1'b0;
				c = c | ESC_OR;
			end
			if (parse_phase != PH_CSUM)
				running_xor = running_xor ^ c;
			case (parse_phase)
			PH_TYPE: begin
				held_type = c;
				parse_phase = accept_bits[c] ? PH_LEN : PH_WAIT;
			end
			PH_LEN: begin
				held_length = c;
				if (!accept_bits[held_type]) begin
					parse_phase = PH_WAIT;
				end else if (c == 8'd0) begin
					parse_phase = PH_CSUM;
				end else if (c > MAX_DATA_DEF) begin
					expect_result(4'd0, 8'd0, STATUS_TOO_LONG, 1'b1);
					parse_phase = PH_WAIT;
				end else begin
					data_count = 0;
					parse_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				if (!accept_bits[held_type] || data_count >= MAX_DATA_DEF) begin
					parse_phase = PH_WAIT;
				end else begin
					frame_buf[data_count] = c;
					data_count++;
					if (data_count == held_length)
						parse_phase = PH_CSUM;
				end
			end
			PH_CSUM: begin
				if (running_xor == c) begin
					if (held_length == 8'd0) begin
						expect_result(4'd0, 8'd0, STATUS_GOOD, 1'b1);
					end else begin
						for (int i = 0; i < held_length && i < MAX_DATA_DEF; i++)
							expect_result(i[3:0], frame_buf[i], STATUS_GOOD,
								(i + 1 == held_length));
					end
				end else begin
					expect_result(4'd0, 8'd0, STATUS_BAD_SUM, 1'b1);
				end
				parse_phase = PH_WAIT;
			end
			default: ;
			endcase
		end
	endfunction

	// ------------------------------------------------------------------------
	// result checking and output pacing
	// ------------------------------------------------------------------------

	function automatic bit fields_match(input result_t a, input result_t b);
		return a.frame_type === b.frame_type && a.frame_length === b.frame_length &&
			a.byte_index === b.byte_index && a.data_byte === b.data_byte &&
			a.status === b.status && a.last === b.last;
	endfunction

	task automatic report_result(input string what, input result_t want, input result_t got);
		fail_count++;
		if (shown_count < 10) begin
			shown_count++;
			$display("%0t %s: exp type %h len %h idx %h data %h status %0d last %0d",
				$realtime, what, want.frame_type, want.frame_length, want.byte_index,
				want.data_byte, want.status, want.last);
			$display("%0t %s: got type %h len %h idx %h data %h status %0d last %0d",
				$realtime, what, got.frame_type, got.frame_length, got.byte_index,
				got.data_byte, got.status, got.last);
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		// result request taken at this edge
		if (arst_n && out_valid && out_ready) begin
			got = {frame_type, frame_length, byte_index, data_byte, status, last};
			if (expected_results.size() == 0) begin
				report_result("unexpected result", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (!fields_match(want, got))
					report_result("result mismatch", want, got);
			end
		end
		// ready for the next edge: long hold-off first, then the chosen pattern
		rx_pattern <= {rx_pattern[11:0], rx_pattern[12]};
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= hold_len;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(3) != 0);
			default:   out_ready <= rx_pattern[0];
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// offer one raw byte and hold it until the request is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		in_valid <= 1'b1;
		rx_byte  <= b;
		offering = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (parse_phase != PH_WAIT || b == START_BYTE)
			counted_bytes++;
		deframe_byte(b);
		// end of burst: drop valid for a random gap
		if (tx_gaps) begin
			if (tx_burst_left == 0) begin
				tx_burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 15);
				in_valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				tx_burst_left--;
			end
		end
	endtask

	// send a decoded value, escaping where required and sometimes where optional
	task automatic send_value(input logic [7:0] v);
		logic [7:0] strip;
		if (v == START_BYTE || v == ESC_BYTE ||
				((v & ESC_OR) == ESC_OR && $urandom_range(3) == 0)) begin
			strip = {1'b0, 3'($urandom_range(1, 7)), 4'b0000};
			send_byte(ESC_BYTE);
			send_byte(v & ~strip);
		end else begin
			send_byte(v);
		end
	endtask

	// stop offering, wait for every owed result, then let the block settle
	task automatic wait_for_results();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// program all four accept map words once the block is idle
	task automatic set_accept_map(input logic [255:0] map);
		wait_for_results();
		write_reg(REG_MAP_0, map[63:0]);
		write_reg(REG_MAP_1, map[127:64]);
		write_reg(REG_MAP_2, map[191:128]);
		write_reg(REG_MAP_3, map[255:192]);
		accept_bits = map;
	endtask

	// framing bytes show up often in the data
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 10) return START_BYTE;
		if (r < 20) return ESC_BYTE;
		if (r < 25) return 8'h00;
		if (r < 30) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_type(input bit want_accepted);
		logic [7:0] t;
		t = 8'($urandom_range(255));
		if (want_accepted) begin
			for (int k = 0; k < 200 && !accept_bits[t]; k++)
				t = 8'($urandom_range(255));
		end
		return t;
	endfunction

	// mostly short frames, some at the buffer size, a few too long
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 15) return 0;
		if (r < 60) return $urandom_range(1, 4);
		if (r < 80) return $urandom_range(5, 15);
		if (r < 92) return MAX_DATA_DEF;
		if (r < 96) return $urandom_range(MAX_DATA_DEF + 1, 254);
		return 255;
	endfunction

	// one frame; sum_flip spoils the checksum, cut_at stops before that data byte
	task automatic send_frame(input logic [7:0] ftype, input int len,
			input logic [7:0] sum_flip, input int cut_at);
		logic [7:0] sum;
		logic [7:0] v;
		send_byte(START_BYTE);
		send_value(ftype);
		send_value(len[7:0]);
		sum = ftype ^ len[7:0];
		if (len > MAX_DATA_DEF)
			return;
		for (int i = 0; i < len; i++) begin
			if (i == cut_at)
				return;
			v = pick_byte();
			send_value(v);
			sum = sum ^ v;
		end
		send_value(sum ^ sum_flip);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// map still at reset: every frame is dropped, idle bytes are ignored
	task automatic test_reset_map_rejects();
		tx_gaps = 1'b1;
		rx_mode <= RX_ALWAYS;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ESC_BYTE);
		send_byte(8'h0E);
		send_frame(8'h01, 0, 8'h00, -1);
		wait_for_results();
	endtask

	// empty frame, both length errors and a checksum error
	task automatic test_empty_and_errors();
		set_accept_map('1);
		rx_mode <= RX_PATTERN;
		send_frame(8'h00, 0, 8'h00, -1);
		send_frame(8'hFF, MAX_DATA_DEF + 1, 8'h00, -1);
		send_frame(8'hFF, 255, 8'h00, -1);
		send_frame(8'h42, 1, 8'h5A, -1);
		wait_for_results();
	endtask

	// escapes before a start, escaped type and data, restart mid-frame
	task automatic test_escapes_and_restart();
		set_accept_map('1);
		rx_mode <= RX_RANDOM;
		send_byte(ESC_BYTE);
		send_frame(START_BYTE, 0, 8'h00, -1);
		send_byte(START_BYTE);
		send_value(8'h01);
		send_value(8'h02);
		send_value(ESC_BYTE);
		send_value(START_BYTE);
		send_value(8'h01 ^ 8'h02 ^ ESC_BYTE ^ START_BYTE);
		send_frame(8'h10, 2, 8'h00, 1);
		send_frame(8'h10, 1, 8'h00, -1);
		wait_for_results();
	endtask

	// a type that becomes rejected drops the frame at the length or a data byte
	task automatic test_map_change_mid_frame();
		logic [255:0] map;
		set_accept_map('1);
		rx_mode <= RX_ALWAYS;
		send_byte(START_BYTE);
		send_value(8'h20);
		map = '1;
		map[8'h20] = 1'b0;
		set_accept_map(map);
		send_value(8'h03);
		send_value(8'h11);
		set_accept_map('1);
		send_byte(START_BYTE);
		send_value(8'hC1);
		send_value(8'h02);
		send_value(8'hAA);
		map = '1;
		map[8'hC1] = 1'b0;
		set_accept_map(map);
		send_value(8'hBB);
		send_value(8'hC1 ^ 8'h02 ^ 8'hAA ^ 8'hBB);
		wait_for_results();
	endtask

	// random traffic: mostly good frames, some broken ones and some noise
	task automatic test_random_frames(input logic [255:0] map, input bit gaps,
			input rx_mode_t mode, input int byte_goal, input int result_goal);
		int kind;
		int len;
		int byte_stop;
		int result_stop;
		set_accept_map(map);
		tx_gaps = gaps;
		rx_mode <= mode;
		byte_stop = counted_bytes + byte_goal;
		result_stop = predicted_results + result_goal;
		while (counted_bytes < byte_stop || predicted_results < result_stop) begin
			kind = $urandom_range(99);
			len = pick_len();
			if (kind < 70) begin
				send_frame(pick_type(1'b1), len, 8'h00, -1);
			end else if (kind < 80) begin
				send_frame(pick_type(1'b1), len, 8'($urandom_range(1, 255)), -1);
			end else if (kind < 86) begin
				send_frame(pick_type(1'b0), len, 8'h00, -1);
			end else if (kind < 92) begin
				send_frame(pick_type(1'b1), len, 8'h00, (len > 0) ? $urandom_range(len - 1) : -1);
			end else if (kind < 96) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
			end else begin
				send_byte(ESC_BYTE);
				send_frame(pick_type(1'b1), len, 8'h00, -1);
			end
		end
		wait_for_results();
	endtask

	// output held off for a long stretch while full frames keep coming
	task automatic test_output_backpressure();
		set_accept_map('1);
		tx_gaps = 1'b0;
		rx_mode <= RX_RANDOM;
		hold_len <= 400;
		hold_req <= hold_req + 1;
		repeat (2) send_frame(pick_type(1'b1), MAX_DATA_DEF, 8'h00, -1);
		wait_for_results();
	endtask

	// sparse map: both end codes, the framing codes and one code in the middle
	function automatic logic [255:0] sparse_map();
		logic [255:0] m;
		m = '0;
		m[8'h00] = 1'b1;
		m[8'hFF] = 1'b1;
		m[START_BYTE] = 1'b1;
		m[ESC_BYTE] = 1'b1;
		m[$urandom_range(128, 191)] = 1'b1;
		return m;
	endfunction

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_map_rejects();
		test_empty_and_errors();
		test_escapes_and_restart();
		test_map_change_mid_frame();
		test_random_frames('1, 1'b1, RX_RANDOM, 10, 3);
		test_random_frames({$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom}, 1'b1, RX_PATTERN, 10, 3);
		test_output_backpressure();
		test_random_frames(sparse_map(), 1'b0, RX_ALWAYS, 8, 2);

		wait_for_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS escaped_frame_deframer_xor_core");
		end else begin
			$display("FAIL escaped_frame_deframer_xor_core");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/efdx_pkg.sv
hw/rtl/efdx_store.sv
hw/rtl/escaped_frame_deframer_xor_core.sv
verif/escaped_frame_deframer_xor_core_tb.sv
